// ===== rtl/frs_pkg.sv =====
package frs_pkg;

  // default geometry
  localparam int ADC_BITS_DEF  = 10;
  localparam int DIST_BITS_DEF = 12;

  // queue depth between stages and on the result side (power of two)
  localparam int QDEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int THR_W      = 10;
  localparam int LVL_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAS_HIGH    = 3'd0,
    CFG_GAS_MID     = 3'd1,
    CFG_TEMP_HIGH   = 3'd2,
    CFG_TEMP_MID    = 3'd3,
    CFG_TEMP_LOW    = 3'd4,
    CFG_ALARM_LEVEL = 3'd5,
    CFG_WARN_LEVEL  = 3'd6
  } cfg_idx_t;

  localparam logic [THR_W-1:0] GAS_HIGH_RST  = 10'd100;
  localparam logic [THR_W-1:0] GAS_MID_RST   = 10'd50;
  localparam logic [THR_W-1:0] TEMP_HIGH_RST = 10'd50;
  localparam logic [THR_W-1:0] TEMP_MID_RST  = 10'd30;
  localparam logic [THR_W-1:0] TEMP_LOW_RST  = 10'd10;
  localparam logic [LVL_W-1:0] ALARM_LVL_RST = 4'd4;
  localparam logic [LVL_W-1:0] WARN_LVL_RST  = 4'd3;

  // one result word
  typedef struct packed {
    logic [1:0]       flame_level;
    logic [1:0]       gas_level;
    logic [1:0]       temp_level;
    logic [LVL_W-1:0] severity_sum;
    logic             alarm;
    logic             warning;
    logic             occupied_now;
    logic             presence_now;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

// ===== rtl/frs_fifo.sv =====
module frs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  // DEPTH must be a power of two so pointers wrap on their own
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/frs_front.sv =====
module frs_front #(
  parameter int ADC_BITS  = 10,
  parameter int DIST_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic                   in_func,
  input  logic [ADC_BITS-1:0]    in_flame_sample,
  input  logic [ADC_BITS-1:0]    in_gas_sample,
  input  logic [ADC_BITS-1:0]    in_temp_sample,
  input  logic [DIST_BITS-1:0]   in_distance_cm,
  input  logic                   in_card_seen,
  input  logic                   mid_full,
  output logic                   mid_push,
  output logic [5*ADC_BITS+16:0] mid_rec
);
  import frs_pkg::*;

  localparam int A  = ADC_BITS;
  localparam int D  = DIST_BITS;
  localparam int SW = A + 4;   // signed working width

  // channel 0 flame, 1 gas, 2 temperature
  logic [A:0]   cmn_r [3];
  logic [A:0]   cmx_r [3];
  logic [A:0]   cmn_nxt [3];
  logic [A:0]   cmx_nxt [3];
  logic [A-1:0] smp [3];
  logic [D-1:0] dmin_r, dmax_r, dmin_nxt, dmax_nxt;
  logic [D:0]   dsum;
  logic [D-1:0] dmid;
  logic         occ_r, pres_r, occ_nxt, pres_nxt;
  logic         accept;

  logic signed [SW-1:0] mn_s [3];
  logic signed [SW-1:0] mx_s [3];
  logic signed [SW-1:0] v_s  [3];
  logic signed [SW-1:0] f_full, g_full, t_full, rf_full, rg_full;

  assign accept   = push && !mid_full;
  assign full     = mid_full;
  assign mid_push = accept;

  assign smp[0] = in_flame_sample;
  assign smp[1] = in_gas_sample;
  assign smp[2] = in_temp_sample;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cmn_nxt[k] = cmn_r[k];
      cmx_nxt[k] = cmx_r[k];
      if (!in_func && ({1'b0, smp[k]} < cmn_r[k])) cmn_nxt[k] = {1'b0, smp[k]};
      if (!in_func && ({1'b0, smp[k]} > cmx_r[k])) cmx_nxt[k] = {1'b0, smp[k]};
      mn_s[k] = $signed({3'b000, cmn_r[k]});
      mx_s[k] = $signed({3'b000, cmx_r[k]});
      v_s[k]  = $signed({4'b0000, smp[k]});
    end
  end

  always_comb begin
    dmin_nxt = dmin_r;
    dmax_nxt = dmax_r;
    if (!in_func && (in_distance_cm < dmin_r)) dmin_nxt = in_distance_cm;
    if (!in_func && (in_distance_cm > dmax_r)) dmax_nxt = in_distance_cm;
  end

  // occupancy toggles first, presence then copies the new value
  assign dsum     = {1'b0, dmin_r} + {1'b0, dmax_r};
  assign dmid     = dsum[D:1];
  assign occ_nxt  = occ_r ^ (in_func & in_card_seen);
  assign pres_nxt = (in_func && (in_distance_cm < dmid)) ? occ_nxt : pres_r;

  // grading terms from the calibrated bounds (monitor words never move them)
  assign f_full  = (mn_s[0] + mx_s[0] - (v_s[0] <<< 1)) <<< 1;
  assign rf_full = mx_s[0] - mn_s[0];
  assign g_full  = (v_s[1] <<< 1) - mn_s[1] - mx_s[1];
  assign rg_full = mx_s[1] - mn_s[1];
  assign t_full  = (v_s[2] <<< 1) - mn_s[2] - mx_s[2];

  assign mid_rec = {in_func, occ_nxt, pres_nxt,
                    f_full,
                    rf_full[A+1:0],
                    g_full[A+2:0],
                    rg_full[A+1:0],
                    t_full[A+2:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        cmn_r[k] <= (A+1)'(1) << A;
        cmx_r[k] <= '0;
      end
      dmin_r <= '1;
      dmax_r <= '0;
      occ_r  <= 1'b0;
      pres_r <= 1'b0;
    end else if (accept) begin
      for (int k = 0; k < 3; k++) begin
        cmn_r[k] <= cmn_nxt[k];
        cmx_r[k] <= cmx_nxt[k];
      end
      dmin_r <= dmin_nxt;
      dmax_r <= dmax_nxt;
      occ_r  <= occ_nxt;
      pres_r <= pres_nxt;
    end
  end

endmodule

// ===== rtl/frs_back.sv =====
module frs_back #(
  parameter int ADC_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [frs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               mid_empty,
  input  logic [5*ADC_BITS+16:0]             mid_rec,
  output logic                               mid_pop,
  input  logic                               res_full,
  output logic                               res_push,
  output frs_pkg::res_t                      res
);
  import frs_pkg::*;

  localparam int A     = ADC_BITS;
  localparam int REC_W = 5*A + 17;
  localparam int FW    = A + 4;
  localparam int RW    = A + 2;
  localparam int GW    = A + 3;
  localparam int C     = A + 6;   // compare width

  logic [THR_W-1:0] gas_high_r, gas_mid_r, temp_high_r, temp_mid_r, temp_low_r;
  logic [LVL_W-1:0] alarm_lvl_r, warn_lvl_r;

  logic              mon, occ, pres;
  logic [FW-1:0]     f_raw;
  logic [RW-1:0]     rf_raw, rg_raw;
  logic [GW-1:0]     g_raw, t_raw;
  logic signed [C-1:0] f, rf, g, rg, t;
  logic signed [C-1:0] rf4, rf5, rf6, rg2;
  logic signed [C-1:0] gh2, gm2, th2, tm2, tl2;
  logic [1:0]        lf, lg, lt;
  logic [LVL_W-1:0]  sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_high_r  <= GAS_HIGH_RST;
      gas_mid_r   <= GAS_MID_RST;
      temp_high_r <= TEMP_HIGH_RST;
      temp_mid_r  <= TEMP_MID_RST;
      temp_low_r  <= TEMP_LOW_RST;
      alarm_lvl_r <= ALARM_LVL_RST;
      warn_lvl_r  <= WARN_LVL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GAS_HIGH:    gas_high_r  <= cfg_data[THR_W-1:0];
        CFG_GAS_MID:     gas_mid_r   <= cfg_data[THR_W-1:0];
        CFG_TEMP_HIGH:   temp_high_r <= cfg_data[THR_W-1:0];
        CFG_TEMP_MID:    temp_mid_r  <= cfg_data[THR_W-1:0];
        CFG_TEMP_LOW:    temp_low_r  <= cfg_data[THR_W-1:0];
        CFG_ALARM_LEVEL: alarm_lvl_r <= cfg_data[LVL_W-1:0];
        CFG_WARN_LEVEL:  warn_lvl_r  <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // record unpack
  assign mon    = mid_rec[REC_W-1];
  assign occ    = mid_rec[REC_W-2];
  assign pres   = mid_rec[REC_W-3];
  assign f_raw  = mid_rec[2*GW+2*RW+FW-1 : 2*GW+2*RW];
  assign rf_raw = mid_rec[2*GW+2*RW-1 : 2*GW+RW];
  assign g_raw  = mid_rec[2*GW+RW-1 : GW+RW];
  assign rg_raw = mid_rec[GW+RW-1 : GW];
  assign t_raw  = mid_rec[GW-1:0];

  assign f  = $signed({{(C-FW){f_raw[FW-1]}}, f_raw});
  assign rf = $signed({{(C-RW){rf_raw[RW-1]}}, rf_raw});
  assign g  = $signed({{(C-GW){g_raw[GW-1]}}, g_raw});
  assign rg = $signed({{(C-RW){rg_raw[RW-1]}}, rg_raw});
  assign t  = $signed({{(C-GW){t_raw[GW-1]}}, t_raw});

  assign rf4 = rf <<< 2;
  assign rf5 = rf4 + rf;
  assign rf6 = rf4 + (rf <<< 1);
  assign rg2 = rg <<< 1;

  assign gh2 = $signed({{(C-THR_W-1){1'b0}}, gas_high_r,  1'b0});
  assign gm2 = $signed({{(C-THR_W-1){1'b0}}, gas_mid_r,   1'b0});
  assign th2 = $signed({{(C-THR_W-1){1'b0}}, temp_high_r, 1'b0});
  assign tm2 = $signed({{(C-THR_W-1){1'b0}}, temp_mid_r,  1'b0});
  assign tl2 = $signed({{(C-THR_W-1){1'b0}}, temp_low_r,  1'b0});

  always_comb begin
    if      (f > rf6) lf = 2'd3;
    else if (f > rf5) lf = 2'd2;
    else if (f > rf4) lf = 2'd1;
    else              lf = 2'd0;

    if      (g > gh2) lg = 2'd3;
    else if (g > gm2) lg = 2'd2;
    else if (g > rg2) lg = 2'd1;
    else              lg = 2'd0;

    if      (t > th2) lt = 2'd3;
    else if (t > tm2) lt = 2'd2;
    else if (t > tl2) lt = 2'd1;
    else              lt = 2'd0;
  end

  assign sum = {2'b00, lf} + {2'b00, lg} + {2'b00, lt};

  always_comb begin
    res.occupied_now = occ;
    res.presence_now = pres;
    if (mon) begin
      res.flame_level  = lf;
      res.gas_level    = lg;
      res.temp_level   = lt;
      res.severity_sum = sum;
      res.alarm        = (sum >= alarm_lvl_r) && occ && pres;
      res.warning      = (sum >= warn_lvl_r) && (sum < alarm_lvl_r);
    end else begin
      res.flame_level  = 2'd0;
      res.gas_level    = 2'd0;
      res.temp_level   = 2'd0;
      res.severity_sum = '0;
      res.alarm        = 1'b0;
      res.warning      = 1'b0;
    end
  end

  assign mid_pop  = !mid_empty && !res_full;
  assign res_push = mid_pop;

endmodule

// ===== rtl/fire_risk_sensor_scorer.sv =====
// Path: an accepted word goes through the front queue, then the grading logic, into the result
//   queue, where it shows on the result ports; it is held back only while pop is held low.
// Throughput: one word per cycle while neither queue is full; the two-entry queues on either
//   side of the grading logic keep push and pop independent.
// Reset (rst_n low, synchronous): queues empty, calibration bounds back to their
//   uncalibrated values, occupancy and presence cleared, thresholds to defaults.
module fire_risk_sensor_scorer #(
  parameter int ADC_BITS  = frs_pkg::ADC_BITS_DEF,
  parameter int DIST_BITS = frs_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input side
  input  logic                           push,
  output logic                           full,
  input  logic                           in_func,
  input  logic [ADC_BITS-1:0]            in_flame_sample,
  input  logic [ADC_BITS-1:0]            in_gas_sample,
  input  logic [ADC_BITS-1:0]            in_temp_sample,
  input  logic [DIST_BITS-1:0]           in_distance_cm,
  input  logic                           in_card_seen,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     out_flame_level,
  output logic [1:0]                     out_gas_level,
  output logic [1:0]                     out_temp_level,
  output logic [frs_pkg::LVL_W-1:0]      out_severity_sum,
  output logic                           out_alarm,
  output logic                           out_warning,
  output logic                           out_occupied_now,
  output logic                           out_presence_now,
  // configuration
  input  logic                           cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [frs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import frs_pkg::*;

  localparam int REC_W = 5*ADC_BITS + 17;

  // front -> mid queue
  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [REC_W-1:0] front_rec, mid_rec;

  // back -> result queue
  logic             res_push, res_full;
  res_t             res_in, res_out;

  // Front: takes words, owns the calibration bounds and the occupancy/presence
  // flags, and forms the doubled grading terms against the current bounds.
  frs_front #(
    .ADC_BITS  (ADC_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_flame_sample (in_flame_sample),
    .in_gas_sample   (in_gas_sample),
    .in_temp_sample  (in_temp_sample),
    .in_distance_cm  (in_distance_cm),
    .in_card_seen    (in_card_seen),
    .mid_full        (mid_full),
    .mid_push        (mid_push),
    .mid_rec         (front_rec)
  );

  frs_fifo #(
    .W     (REC_W),
    .DEPTH (QDEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (front_rec),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_rec),
    .empty (mid_empty)
  );

  // Back: holds the thresholds, grades the three channels, sums and decides
  // alarm / warning. Moves one word whenever the mid queue holds one and the result queue has room.
  frs_back #(
    .ADC_BITS (ADC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .mid_empty (mid_empty),
    .mid_rec   (mid_rec),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  frs_fifo #(
    .W     (RES_W),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign out_flame_level  = res_out.flame_level;
  assign out_gas_level    = res_out.gas_level;
  assign out_temp_level   = res_out.temp_level;
  assign out_severity_sum = res_out.severity_sum;
  assign out_alarm        = res_out.alarm;
  assign out_warning      = res_out.warning;
  assign out_occupied_now = res_out.occupied_now;
  assign out_presence_now = res_out.presence_now;

endmodule

// ===== tb/frs_score_monitor.sv =====
`timescale 1ns / 1ps
module frs_score_monitor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic                              full,
  input  logic                              in_func,
  input  logic [frs_pkg::ADC_BITS_DEF-1:0]  in_flame_sample,
  input  logic [frs_pkg::ADC_BITS_DEF-1:0]  in_gas_sample,
  input  logic [frs_pkg::ADC_BITS_DEF-1:0]  in_temp_sample,
  input  logic [frs_pkg::DIST_BITS_DEF-1:0] in_distance_cm,
  input  logic                              in_card_seen,
  input  logic                              empty,
  input  logic                              pop,
  input  logic [1:0]                        out_flame_level,
  input  logic [1:0]                        out_gas_level,
  input  logic [1:0]                        out_temp_level,
  input  logic [frs_pkg::LVL_W-1:0]         out_severity_sum,
  input  logic                              out_alarm,
  input  logic                              out_warning,
  input  logic                              out_occupied_now,
  input  logic                              out_presence_now,
  input  logic                              cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [frs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                fail_count,
  output int                                pending_words
);
  import frs_pkg::*;

  // thresholds
  logic [THR_W-1:0] gas_high, gas_mid, temp_high, temp_mid, temp_low;
  logic [LVL_W-1:0] alarm_lvl, warn_lvl;

  // calibration bounds and room state
  logic [ADC_BITS_DEF:0]    ch_lo [3];
  logic [ADC_BITS_DEF:0]    ch_hi [3];
  logic [DIST_BITS_DEF-1:0] dist_lo, dist_hi;
  logic                     occupied, presence;

  res_t score_queue [$];
  res_t want_w;
  int   fails = 0;

  assign fail_count = fails;

  function automatic res_t score_word(input logic mon,
                                      input logic [ADC_BITS_DEF-1:0] fl, ga, te,
                                      input logic [DIST_BITS_DEF-1:0] dcm,
                                      input logic card);
    res_t w;
    int   smp [3];
    int   lo, hi, rng, dlt, dmid, sum;
    w = '0;
    smp[0] = int'(fl);
    smp[1] = int'(ga);
    smp[2] = int'(te);
    if (!mon) begin
      for (int k = 0; k < 3; k++) begin
        if (smp[k] > int'(ch_hi[k])) ch_hi[k] = smp[k][ADC_BITS_DEF:0];
        if (smp[k] < int'(ch_lo[k])) ch_lo[k] = smp[k][ADC_BITS_DEF:0];
      end
      if (dcm > dist_hi) dist_hi = dcm;
      if (dcm < dist_lo) dist_lo = dcm;
    end else begin
      dmid = (int'(dist_lo) + int'(dist_hi)) >>> 1;
      if (card) occupied = !occupied;
      if (int'(dcm) < dmid) presence = occupied;
      // flame: lower reading is worse, compared in quarter-range steps
      lo  = ch_lo[0];
      hi  = ch_hi[0];
      rng = hi - lo;
      dlt = 2 * (lo + hi - 2 * smp[0]);
      w.flame_level = (dlt > 6 * rng) ? 2'd3 : (dlt > 5 * rng) ? 2'd2 :
                      (dlt > 4 * rng) ? 2'd1 : 2'd0;
      lo  = ch_lo[1];
      hi  = ch_hi[1];
      rng = hi - lo;
      dlt = 2 * smp[1] - lo - hi;
      w.gas_level = (dlt > 2 * int'(gas_high)) ? 2'd3 : (dlt > 2 * int'(gas_mid)) ? 2'd2 :
                    (dlt > 2 * rng) ? 2'd1 : 2'd0;
      dlt = 2 * smp[2] - int'(ch_lo[2]) - int'(ch_hi[2]);
      w.temp_level = (dlt > 2 * int'(temp_high)) ? 2'd3 : (dlt > 2 * int'(temp_mid)) ? 2'd2 :
                     (dlt > 2 * int'(temp_low)) ? 2'd1 : 2'd0;
      sum = int'(w.flame_level) + int'(w.gas_level) + int'(w.temp_level);
      w.severity_sum = sum[LVL_W-1:0];
      w.alarm   = (sum >= int'(alarm_lvl)) && occupied && presence;
      w.warning = (sum >= int'(warn_lvl)) && (sum < int'(alarm_lvl));
    end
    w.occupied_now = occupied;
    w.presence_now = presence;
    return w;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gas_high  = GAS_HIGH_RST;
      gas_mid   = GAS_MID_RST;
      temp_high = TEMP_HIGH_RST;
      temp_mid  = TEMP_MID_RST;
      temp_low  = TEMP_LOW_RST;
      alarm_lvl = ALARM_LVL_RST;
      warn_lvl  = WARN_LVL_RST;
      for (int k = 0; k < 3; k++) begin
        ch_lo[k] = (ADC_BITS_DEF+1)'(1) << ADC_BITS_DEF;
        ch_hi[k] = '0;
      end
      dist_lo  = '1;
      dist_hi  = '0;
      occupied = 1'b0;
      presence = 1'b0;
      score_queue.delete();
    end else begin
      if (pop && !empty) begin
        if (score_queue.size() == 0) begin
          $error("result word with no score pending");
          fails++;
        end else begin
          want_w = score_queue.pop_front();
          check_field("flame_level", want_w.flame_level, out_flame_level);
          check_field("gas_level", want_w.gas_level, out_gas_level);
          check_field("temp_level", want_w.temp_level, out_temp_level);
          check_field("severity_sum", want_w.severity_sum, out_severity_sum);
          check_field("alarm", want_w.alarm, out_alarm);
          check_field("warning", want_w.warning, out_warning);
          check_field("occupied_now", want_w.occupied_now, out_occupied_now);
          check_field("presence_now", want_w.presence_now, out_presence_now);
        end
      end
      if (push && !full)
        score_queue.push_back(score_word(in_func, in_flame_sample, in_gas_sample,
                                         in_temp_sample, in_distance_cm, in_card_seen));
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAS_HIGH:    gas_high  = cfg_data[THR_W-1:0];
          CFG_GAS_MID:     gas_mid   = cfg_data[THR_W-1:0];
          CFG_TEMP_HIGH:   temp_high = cfg_data[THR_W-1:0];
          CFG_TEMP_MID:    temp_mid  = cfg_data[THR_W-1:0];
          CFG_TEMP_LOW:    temp_low  = cfg_data[THR_W-1:0];
          CFG_ALARM_LEVEL: alarm_lvl = cfg_data[LVL_W-1:0];
          CFG_WARN_LEVEL:  warn_lvl  = cfg_data[LVL_W-1:0];
          default: ;  // unused index, no effect
        endcase
      end
    end
    pending_words = score_queue.size();
  end

endmodule

// ===== tb/fire_risk_sensor_scorer_test.sv =====
`timescale 1ns / 1ps
module fire_risk_sensor_scorer_test;
  import frs_pkg::*;

  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 140;
  localparam int LONG_HOLD   = 60;   // receiver hold-off, in cycles

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic                     push = 1'b0;
  logic                     full;
  logic                     in_func = 1'b0;
  logic [ADC_BITS_DEF-1:0]  in_flame_sample = '0;
  logic [ADC_BITS_DEF-1:0]  in_gas_sample = '0;
  logic [ADC_BITS_DEF-1:0]  in_temp_sample = '0;
  logic [DIST_BITS_DEF-1:0] in_distance_cm = '0;
  logic                     in_card_seen = 1'b0;

  // result channel
  logic             empty;
  logic             pop = 1'b0;
  logic [1:0]       out_flame_level, out_gas_level, out_temp_level;
  logic [LVL_W-1:0] out_severity_sum;
  logic             out_alarm, out_warning, out_occupied_now, out_presence_now;

  // config port
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_words;

  // idling knobs, percent per cycle
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // bumping this asks the pop process for one long hold-off
  int hold_ticket   = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  always #1 clk = ~clk;

  fire_risk_sensor_scorer u_dut (.*);

  frs_score_monitor u_score (.*);

  // hard stop in case the block hangs
  initial begin
    #400000;
    $display("fire_risk_sensor_scorer test failed");
    $finish;
  end

  // receiver: random stalls, plus the long hold-off, counted here
  always @(negedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one word and hold it until the block takes it.
  // Called and returns just after a falling edge.
  task automatic put_word(input logic f, input logic [ADC_BITS_DEF-1:0] fl, ga, te,
                          input logic [DIST_BITS_DEF-1:0] d, input logic c);
    bit taken;
    taken = 1'b0;
    push            <= 1'b1;
    in_func         <= f;
    in_flame_sample <= fl;
    in_gas_sample   <= ga;
    in_temp_sample  <= te;
    in_distance_cm  <= d;
    in_card_seen    <= c;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end
  endtask

  // Random word: mostly monitor samples over the full range, some
  // calibration samples kept within +-spread of mid scale so the
  // flame and gas grades stay reachable.
  task automatic random_word(input int spread);
    logic [ADC_BITS_DEF-1:0]  fl, ga, te;
    logic [DIST_BITS_DEF-1:0] d;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    if ($urandom_range(99) < 15) begin
      fl = ADC_BITS_DEF'($urandom_range(512 + spread, 512 - spread));
      ga = ADC_BITS_DEF'($urandom_range(512 + spread, 512 - spread));
      te = ADC_BITS_DEF'($urandom_range(512 + spread, 512 - spread));
      d  = DIST_BITS_DEF'($urandom_range(2048 + 4 * spread, 2048 - 4 * spread));
      put_word(1'b0, fl, ga, te, d, 1'($urandom));
    end else begin
      put_word(1'b1, ADC_BITS_DEF'($urandom), ADC_BITS_DEF'($urandom),
               ADC_BITS_DEF'($urandom), DIST_BITS_DEF'($urandom),
               $urandom_range(3) == 0);
    end
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Full register set; level words carry random junk above bit 3,
  // and the spare index gets a random write too.
  task automatic set_thresholds(input int gh, gm, th, tm, tl, input logic [3:0] al, wl);
    cfg_put(CFG_GAS_HIGH, THR_W'(gh));
    cfg_put(CFG_GAS_MID, THR_W'(gm));
    cfg_put(CFG_TEMP_HIGH, THR_W'(th));
    cfg_put(CFG_TEMP_MID, THR_W'(tm));
    cfg_put(CFG_TEMP_LOW, THR_W'(tl));
    cfg_put(CFG_ALARM_LEVEL, {6'($urandom), al});
    cfg_put(CFG_WARN_LEVEL, {6'($urandom), wl});
    cfg_put(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Stop sending and let every scored word come back.
  task automatic drain;
    push <= 1'b0;
    wait (pending_words == 0);
    @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int spread;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed, reset thresholds ---
    // nothing calibrated yet: inverted range makes flame/gas grade hot
    put_word(1'b1, 10'd0, 10'd1023, 10'd1023, 12'd0, 1'b1);     // card on, near
    put_word(1'b1, 10'd1023, 10'd0, 10'd0, 12'd4095, 1'b0);     // far, presence held
    put_word(1'b1, 10'd512, 10'd512, 10'd512, 12'd2046, 1'b1);  // card off, near
    // calibration; card flag ignored
    put_word(1'b0, 10'd500, 10'd480, 10'd520, 12'd1500, 1'b1);
    put_word(1'b0, 10'd560, 10'd540, 10'd580, 12'd2600, 1'b0);
    put_word(1'b0, 10'd530, 10'd510, 10'd550, 12'd2000, 1'b1);
    // distance midpoint now 2050; walk each grade boundary
    put_word(1'b1, 10'd439, 10'd560, 10'd560, 12'd2049, 1'b1);  // occupied, present
    put_word(1'b1, 10'd440, 10'd561, 10'd561, 12'd2050, 1'b0);  // at midpoint: held
    put_word(1'b1, 10'd454, 10'd570, 10'd580, 12'd4095, 1'b0);
    put_word(1'b1, 10'd455, 10'd571, 10'd581, 12'd0, 1'b0);
    put_word(1'b1, 10'd469, 10'd610, 10'd600, 12'd100, 1'b0);
    put_word(1'b1, 10'd470, 10'd611, 10'd601, 12'd100, 1'b0);
    put_word(1'b1, 10'd0, 10'd1023, 10'd1023, 12'd0, 1'b0);     // full alarm
    put_word(1'b1, 10'd0, 10'd1023, 10'd1023, 12'd3000, 1'b1);  // card off: no alarm, no warning
    put_word(1'b1, 10'd1023, 10'd0, 10'd0, 12'd0, 1'b1);        // cool, presence follows
    put_word(1'b1, 10'd0, 10'd1023, 10'd1023, 12'd4095, 1'b0);

    // --- random phases, one register setting each ---
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_thresholds(100, 50, 50, 30, 10, 4'd4, 4'd3);
        1: set_thresholds($urandom_range(255), $urandom_range(255), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255),
                          4'($urandom_range(9)), 4'($urandom_range(9)));
        2: set_thresholds(0, 0, 0, 0, 0, 4'd0, 4'd0);
        3: set_thresholds(1023, 1023, 1023, 1023, 1023, 4'd15, 4'd10);
        4: set_thresholds($urandom_range(255), $urandom_range(255), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255), 4'd9, 4'd0);
        5: set_thresholds($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                          $urandom_range(1023), $urandom_range(1023),
                          4'($urandom_range(15)), 4'($urandom_range(15)));
        default: set_thresholds($urandom_range(150), $urandom_range(150),
                                $urandom_range(150), $urandom_range(150),
                                $urandom_range(150), 4'($urandom_range(9)),
                                4'($urandom_range(9)));
      endcase

      // idling mode: none, sender, receiver, both
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase

      spread = (p == PHASES - 1) ? 511 : 30 + 60 * p;
      if (p == PHASES - 1) begin
        // widest calibration last, since bounds never shrink
        put_word(1'b0, 10'd0, 10'd0, 10'd0, 12'd0, 1'b1);
        put_word(1'b0, 10'd1023, 10'd1023, 10'd1023, 12'd4095, 1'b0);
        put_word(1'b1, 10'd0, 10'd0, 10'd0, 12'd4095, 1'b1);
        put_word(1'b1, 10'd1023, 10'd1023, 10'd1023, 12'd0, 1'b1);
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // back pressure: receiver holds off while words keep coming
        if (n == 20 && (p == 1 || p == 4)) begin
          hold_ticket++;
          for (int b = 0; b < 12; b++)
            put_word(1'b1, ADC_BITS_DEF'($urandom), ADC_BITS_DEF'($urandom),
                     ADC_BITS_DEF'($urandom), DIST_BITS_DEF'($urandom), 1'($urandom));
        end
        // sender waits for the block to run dry, then resumes
        if (n == PHASE_WORDS / 2) begin
          push <= 1'b0;
          wait (pending_words == 0);
          @(negedge clk);
        end
        random_word(spread);
      end
    end

    push <= 1'b0;
    wait (pending_words == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("fire_risk_sensor_scorer test passed");
    end else begin
      $display("fire_risk_sensor_scorer test failed");
    end
    $finish;
  end

endmodule
